[hw/rtl/sq3d_pkg.sv]
package sq3d_pkg;

  localparam int IDX_W  = 8;
  localparam int COMP_W = 16;
  localparam int SQ_W   = 31;  // square of a 16-bit signed value, always >= 0
  localparam int SUM_W  = 32;  // sum of three squares

  typedef logic        [IDX_W-1:0]  idx_t;
  typedef logic signed [COMP_W-1:0] comp_t;

  localparam comp_t COMP_MAX = 16'sd32767;
  localparam idx_t  IDX_LAST = 8'd3;

  typedef enum logic [1:0] {
    SLOT_X,
    SLOT_Y,
    SLOT_Z,
    SLOT_W
  } slot_t;

  // Fields that ride alongside the arithmetic down the pipe.
  typedef struct packed {
    idx_t  idx;
    comp_t a;
    comp_t b;
    comp_t c;
  } side_t;

endpackage

[hw/rtl/sq3d_in_if.sv]
interface sq3d_in_if import sq3d_pkg::*; ();
  logic  valid;
  logic  ready;
  idx_t  missing_index;
  comp_t comp_a;
  comp_t comp_b;
  comp_t comp_c;

  modport source (output valid, output missing_index, output comp_a, output comp_b,
                  output comp_c, input ready);
  modport sink   (input valid, input missing_index, input comp_a, input comp_b,
                  input comp_c, output ready);
endinterface

[hw/rtl/sq3d_out_if.sv]
interface sq3d_out_if import sq3d_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t quat_x;
  comp_t quat_y;
  comp_t quat_z;
  comp_t quat_w;

  modport source (output valid, output quat_x, output quat_y, output quat_z,
                  output quat_w, input ready);
  modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                  input quat_w, output ready);
endinterface

[hw/rtl/smallest_three_quaternion_decode.sv]
// Channel | Dir | Payload                                   | Meaning
// req     | in  | missing_index, comp_a, comp_b, comp_c     | dropped slot + three sent parts
// rsp     | out | quat_x, quat_y, quat_z, quat_w            | rebuilt quaternion
//
// One transaction per cycle sustained while rsp does not stall.
// The pipe is the squares and sum/clamp stages, the square root with one root
// bit per pipeline stage (FRAC_BITS + 1 stages), and the output register.
// rst is synchronous, active high, clears only the valid bits, holds req.ready low.
// A stall on rsp freezes the whole pipe; req.ready drops in the same cycle.
module smallest_three_quaternion_decode import sq3d_pkg::*; #(
  parameter int FRAC_BITS = 15
) (
  input  logic              clk,
  input  logic              rst,
  sq3d_in_if.sink           req,
  sq3d_out_if.source        rsp
);

  localparam int ROOT_W = FRAC_BITS + 1;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int SW     = (ROOT_W > COMP_W) ? ROOT_W : COMP_W;

  // global advance: the pipe moves whenever the output slot is free or drains
  logic adv;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv && !rst;

  side_t in_side;
  assign in_side.idx = req.missing_index;
  assign in_side.a   = req.comp_a;
  assign in_side.b   = req.comp_b;
  assign in_side.c   = req.comp_c;

  // squares, then 1 - a^2 - b^2 - c^2 clamped to [0, 1]
  logic             rad_valid;
  side_t            rad_side;
  logic [RAD_W-1:0] rad;

  sq3d_sumsq #(.FRAC_BITS(FRAC_BITS)) u_sumsq (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (req.valid),
    .in_side   (in_side),
    .out_valid (rad_valid),
    .out_side  (rad_side),
    .out_rad   (rad)
  );

  // floor square root, one bit per stage
  logic              fin_valid;
  side_t             fin_side;
  logic [ROOT_W-1:0] root;

  sq3d_sqrt #(.ROOT_W(ROOT_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (rad_valid),
    .in_side   (rad_side),
    .in_rad    (rad),
    .out_valid (fin_valid),
    .out_side  (fin_side),
    .out_root  (root)
  );

  // saturate: a root of exactly one does not fit Q1.15
  logic [SW-1:0] root_ext;
  comp_t         root_sat;
  assign root_ext = SW'(root);
  assign root_sat = (root_ext > SW'(COMP_MAX)) ? COMP_MAX : comp_t'(root_ext[COMP_W-1:0]);

  // slot placement; an index past w gives an all-zero quaternion
  logic  idx_ok;
  slot_t slot;
  comp_t qx, qy, qz, qw;

  assign idx_ok = (fin_side.idx <= IDX_LAST);
  assign slot   = slot_t'(fin_side.idx[1:0]);

  always_comb begin
    qx = '0;
    qy = '0;
    qz = '0;
    qw = '0;
    if (idx_ok) begin
      unique case (slot)
        SLOT_X: begin
          qx = root_sat;   qy = fin_side.a; qz = fin_side.b; qw = fin_side.c;
        end
        SLOT_Y: begin
          qx = fin_side.a; qy = root_sat;   qz = fin_side.b; qw = fin_side.c;
        end
        SLOT_Z: begin
          qx = fin_side.a; qy = fin_side.b; qz = root_sat;   qw = fin_side.c;
        end
        SLOT_W: begin
          qx = fin_side.a; qy = fin_side.b; qz = fin_side.c; qw = root_sat;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.quat_x <= qx;
      rsp.quat_y <= qy;
      rsp.quat_z <= qz;
      rsp.quat_w <= qw;
    end
  end

`ifndef SYNTHESIS
  a_fin_to_out: assert property (@(posedge clk) disable iff (rst)
    (adv && fin_valid) |=> rsp.valid)
    else $error("finished item did not reach the output register");

  a_bad_idx_zero: assert property (@(posedge clk) disable iff (rst)
    (adv && fin_valid && !idx_ok) |=>
      (rsp.quat_x == '0 && rsp.quat_y == '0 && rsp.quat_z == '0 && rsp.quat_w == '0))
    else $error("out-of-range index gave a nonzero quaternion");
`endif

endmodule

[hw/rtl/sq3d_sumsq.sv]
module sq3d_sumsq import sq3d_pkg::*; #(
  parameter int FRAC_BITS = 15
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  side_t                     in_side,
  output logic                      out_valid,
  output side_t                     out_side,
  output logic [2*FRAC_BITS+1:0]    out_rad
);

  localparam int RAD_W = 2 * FRAC_BITS + 2;
  localparam int CW    = (2 * FRAC_BITS + 1 > SUM_W) ? 2 * FRAC_BITS + 1 : SUM_W;
  localparam logic [CW-1:0] ONE = {{(CW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

  // stage 1: squares
  logic signed [2*COMP_W-1:0] pa, pb, pc;
  logic [SQ_W-1:0] sq_a, sq_b, sq_c;
  logic            v1;
  side_t           side1;

  assign pa = in_side.a * in_side.a;
  assign pb = in_side.b * in_side.b;
  assign pc = in_side.c * in_side.c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_a  <= pa[SQ_W-1:0];
      sq_b  <= pb[SQ_W-1:0];
      sq_c  <= pc[SQ_W-1:0];
      side1 <= in_side;
    end
  end

  // stage 2: 1 - sum, clamped at zero
  logic [SUM_W-1:0] sum;
  logic [CW-1:0]    sum_ext;
  logic [CW-1:0]    rem;

  assign sum     = SUM_W'(sq_a) + SUM_W'(sq_b) + SUM_W'(sq_c);
  assign sum_ext = CW'(sum);
  assign rem     = (sum_ext >= ONE) ? '0 : ONE - sum_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= RAD_W'(rem);
      out_side <= side1;
    end
  end

`ifndef SYNTHESIS
  a_rad_le_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_rad <= RAD_W'(ONE)))
    else $error("radicand above one");
`endif

endmodule

[hw/rtl/sq3d_sqrt.sv]
module sq3d_sqrt import sq3d_pkg::*; #(
  parameter int ROOT_W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  side_t                 in_side,
  input  logic [2*ROOT_W-1:0]   in_rad,
  output logic                  out_valid,
  output side_t                 out_side,
  output logic [ROOT_W-1:0]     out_root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int RW    = ROOT_W + 3;

  // one root bit per stage; index 0 is the stage input
  logic              v    [0:ROOT_W];
  side_t             sd   [0:ROOT_W];
  logic [RAD_W-1:0]  n    [0:ROOT_W];
  logic [RW-1:0]     rm   [0:ROOT_W];
  logic [ROOT_W-1:0] q    [0:ROOT_W];

  assign v[0]  = in_valid;
  assign sd[0] = in_side;
  assign n[0]  = in_rad;
  assign rm[0] = '0;
  assign q[0]  = '0;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [RW-1:0] rm_sh;
    logic [RW-1:0] trial;
    logic          ge;

    // bring down the next two radicand bits, try root*4+1
    assign rm_sh = {rm[s][RW-3:0], n[s][RAD_W-1 -: 2]};
    assign trial = {1'b0, q[s], 2'b01};
    assign ge    = (rm_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[s+1] <= sd[s];
        n[s+1]  <= n[s] << 2;
        rm[s+1] <= ge ? rm_sh - trial : rm_sh;
        q[s+1]  <= {q[s][ROOT_W-2:0], ge};
      end
    end
  end

  assign out_valid = v[ROOT_W];
  assign out_side  = sd[ROOT_W];
  assign out_root  = q[ROOT_W];

`ifndef SYNTHESIS
  // the partial remainder never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rm[ROOT_W][RW-1:RW-2] == 2'b00))
    else $error("square root remainder out of range");
`endif

endmodule

[sim/smallest_three_quaternion_decode_tb.sv]
`timescale 1ns / 1ps

// Testbench for the smallest-three quaternion decoder.
// Each request transaction names the dropped slot and carries the three
// sent components; each response transaction is the rebuilt quaternion.
// A table of directed transactions runs first, then random traffic, with
// bursty requests and a receiver that stalls on its own pattern.
// Responses are checked field by field against an in-order queue of
// predicted quaternions.
module smallest_three_quaternion_decode_tb import sq3d_pkg::*; ();

  localparam int  FRAC_BITS  = 15;
  localparam int  CLK_PERIOD = 4;
  localparam int  PIPE_DEPTH = FRAC_BITS + 4;   // register stages of the decoder, input to rsp
  localparam int  RAND_TXNS  = 730;
  localparam int  HOLD_CYCLES = 120;            // long receiver hold-off, well past pipe depth
  localparam int  WF_SPAN    = 18918;           // 3 * 18918^2 < 2^30: never over one
  localparam int  LIMIT_NS   = 2_000_000;

  localparam comp_t C_MIN  = 16'sh8000;
  localparam comp_t C_MAX  = COMP_MAX;
  localparam comp_t C_HALF = 16'sd16384;
  localparam comp_t C_ZERO = 16'sd0;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
  } quat_t;

  // Directed row: quaternion typed in only where it is obvious.
  typedef struct {
    idx_t  idx;
    comp_t a;
    comp_t b;
    comp_t c;
    bit    known;
    quat_t q;
  } dir_row_t;

  localparam int N_DIR = 20;

  logic clk = 1'b0;
  logic rst;

  sq3d_in_if  req_if ();
  sq3d_out_if rsp_if ();

  smallest_three_quaternion_decode #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  quat_t pending_quats[$];    // predicted responses, oldest first
  int    err_count    = 0;
  int    rsp_checked  = 0;
  int    req_sent     = 0;
  int    bad_idx_sent = 0;
  int    burst_left   = 0;
  bit    hold_request = 1'b0; // set by stimulus, serviced once by the receiver
  bit    hold_done    = 1'b0;

  // Directed table: unit extremes, every slot, invalid indexes,
  // remainder clamped to zero, root saturating at one, bit patterns.
  dir_row_t dir_rows [N_DIR] = '{
    // all sent parts zero: rebuilt part is one, saturated
    '{idx_t'(SLOT_W), C_ZERO, C_ZERO, C_ZERO, 1'b1, '{C_ZERO, C_ZERO, C_ZERO, C_MAX}},
    '{idx_t'(SLOT_X), C_ZERO, C_ZERO, C_ZERO, 1'b1, '{C_MAX, C_ZERO, C_ZERO, C_ZERO}},
    '{idx_t'(SLOT_Y), C_ZERO, C_ZERO, C_ZERO, 1'b1, '{C_ZERO, C_MAX, C_ZERO, C_ZERO}},
    '{idx_t'(SLOT_Z), C_ZERO, C_ZERO, C_ZERO, 1'b1, '{C_ZERO, C_ZERO, C_MAX, C_ZERO}},
    // index above 3: zero quaternion
    '{8'd4,   16'sd1, 16'sd2, 16'sd3, 1'b1, '0},
    '{8'd255, -16'sd1, C_MAX, C_MIN,  1'b1, '0},
    '{8'd128, C_MIN, C_MIN, C_MIN,    1'b1, '0},
    '{8'd170, 16'sh5555, 16'shAAAA, C_MAX, 1'b1, '0},
    // -1.0 alone: remainder exactly zero
    '{idx_t'(SLOT_X), C_MIN, C_ZERO, C_ZERO, 1'b1, '{C_ZERO, C_MIN, C_ZERO, C_ZERO}},
    // squares well over one: clamped, rebuilt part zero
    '{idx_t'(SLOT_W), C_MIN, C_MIN, C_MIN, 1'b1, '{C_MIN, C_MIN, C_MIN, C_ZERO}},
    '{idx_t'(SLOT_Y), C_MAX, C_MAX, C_MAX, 1'b1, '{C_MAX, C_ZERO, C_MAX, C_MAX}},
    '{idx_t'(SLOT_W), C_MAX, C_MIN, C_ZERO, 1'b1, '{C_MAX, C_MIN, C_ZERO, C_ZERO}},
    // three halves: remainder a quarter, root a half
    '{idx_t'(SLOT_W), C_HALF, C_HALF, C_HALF, 1'b1, '{C_HALF, C_HALF, C_HALF, C_HALF}},
    // rest go through the predictor
    '{idx_t'(SLOT_X), C_MAX, C_ZERO, C_ZERO,            1'b0, '0},
    '{idx_t'(SLOT_Z), 16'sd23170, C_ZERO, C_ZERO,       1'b0, '0},
    '{idx_t'(SLOT_X), -16'sd16384, C_HALF, -16'sd16384, 1'b0, '0},
    '{idx_t'(SLOT_Y), 16'sd1, -16'sd1, C_ZERO,          1'b0, '0},
    '{idx_t'(SLOT_W), 16'sd18918, -16'sd18918, 16'sd18918, 1'b0, '0},
    '{idx_t'(SLOT_Z), 16'sh5555, 16'shAAAA, C_ZERO,     1'b0, '0},
    '{idx_t'(SLOT_W), 16'sd100, -16'sd200, 16'sd300,    1'b0, '0}
  };

  // Predictor: an index above 3 gives zero; else place the three parts around
  // the dropped slot and rebuild it as floor(sqrt(clamp(1 - sum of squares))), saturated to max.
  function automatic quat_t rebuild_quat(idx_t idx, comp_t a, comp_t b, comp_t c);
    longint          remain;
    longint unsigned root;
    longint unsigned trial;
    comp_t           rebuilt;
    comp_t           slots[4];
    comp_t           sent[3];
    int              k;
    int              i;
    if (idx > IDX_LAST) begin
      return '0;
    end
    remain = (longint'(1) << (2 * FRAC_BITS)) - longint'(a) * longint'(a)
             - longint'(b) * longint'(b) - longint'(c) * longint'(c);
    if (remain < 0) begin
      remain = 0;
    end
    if (remain > (longint'(1) << (2 * FRAC_BITS))) begin
      remain = longint'(1) << (2 * FRAC_BITS);
    end
    // bit-by-bit root, MSB first; root of one needs bit FRAC_BITS
    root = 0;
    for (i = FRAC_BITS + 1; i >= 0; i--) begin
      trial = root | (longint'(1) << i);
      if (trial * trial <= longint'(remain)) begin
        root = trial;
      end
    end
    rebuilt = (root > longint'(COMP_MAX)) ? COMP_MAX : comp_t'(root);
    sent[0] = a;
    sent[1] = b;
    sent[2] = c;
    k = 0;
    for (i = 0; i < 4; i++) begin
      if (i == int'(idx)) begin
        slots[i] = rebuilt;
      end else begin
        slots[i] = sent[k];
        k++;
      end
    end
    return '{slots[SLOT_X], slots[SLOT_Y], slots[SLOT_Z], slots[SLOT_W]};
  endfunction

  function automatic void check_part(string field, comp_t exp_v, comp_t act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
      err_count++;
    end
  endfunction

  // Sender: bursts of random length separated by random idle gaps.
  // Drives on the falling edge, takes the transaction at the rising edge.
  task automatic issue_txn(idx_t idx, comp_t a, comp_t b, comp_t c,
                           bit known, quat_t known_q);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        req_if.valid = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    req_if.valid         = 1'b1;
    req_if.missing_index = idx;
    req_if.comp_a        = a;
    req_if.comp_b        = b;
    req_if.comp_c        = c;
    do begin
      @(posedge clk);
    end while (!req_if.ready);
    pending_quats.push_back(known ? known_q : rebuild_quat(idx, a, b, c));
    req_sent++;
    if (idx > IDX_LAST) begin
      bad_idx_sent++;
    end
  endtask

  // Receiver: stall mode is redrawn at random as the run goes on (always ready, mostly
  // ready, mostly stalled, periodic); one long hold-off when asked for,
  // so the pipe fills and req.ready has to drop.
  initial begin
    int cyc;
    int mode;
    rsp_if.ready = 1'b0;
    cyc  = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        rsp_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (cyc % 50 == 0) begin
          mode = $urandom_range(0, 3);
        end
        case (mode)
          0: rsp_if.ready = 1'b1;
          1: rsp_if.ready = ($urandom_range(0, 3) != 0);
          2: rsp_if.ready = ($urandom_range(0, 3) == 0);
          default: rsp_if.ready = (cyc % 5 != 0);
        endcase
        cyc++;
      end
    end
  end

  // Response checker: compare every accepted transaction with the oldest
  // prediction.
  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_quats.size() == 0) begin
        $error("unexpected response transaction: x=%0d y=%0d z=%0d w=%0d",
               rsp_if.quat_x, rsp_if.quat_y, rsp_if.quat_z, rsp_if.quat_w);
        err_count++;
      end else begin
        exp_q = pending_quats.pop_front();
        check_part("quat_x", exp_q.x, rsp_if.quat_x);
        check_part("quat_y", exp_q.y, rsp_if.quat_y);
        check_part("quat_z", exp_q.z, rsp_if.quat_z);
        check_part("quat_w", exp_q.w, rsp_if.quat_w);
        rsp_checked++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int    r;
    int    kind;
    idx_t  idx;
    comp_t a;
    comp_t b;
    comp_t c;
    req_if.valid         = 1'b0;
    req_if.missing_index = '0;
    req_if.comp_a        = '0;
    req_if.comp_b        = '0;
    req_if.comp_c        = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (r = 0; r < N_DIR; r++) begin
      issue_txn(dir_rows[r].idx, dir_rows[r].a, dir_rows[r].b, dir_rows[r].c,
                dir_rows[r].known, dir_rows[r].q);
    end

    // Mostly well-formed (valid slot, parts within the unit ball), the
    // rest full-range parts that may overflow one, and invalid indexes.
    for (r = 0; r < RAND_TXNS; r++) begin
      if (r == RAND_TXNS / 2) begin
        hold_request = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        idx = idx_t'($urandom_range(0, 255));
        a   = comp_t'($urandom);
        b   = comp_t'($urandom);
        c   = comp_t'($urandom);
      end else if (kind == 1) begin
        idx = idx_t'($urandom_range(SLOT_X, SLOT_W));
        a   = comp_t'($urandom);
        b   = comp_t'($urandom);
        c   = comp_t'($urandom);
      end else begin
        idx = idx_t'($urandom_range(SLOT_X, SLOT_W));
        a   = comp_t'($urandom_range(0, 2 * WF_SPAN) - WF_SPAN);
        b   = comp_t'($urandom_range(0, 2 * WF_SPAN) - WF_SPAN);
        c   = comp_t'($urandom_range(0, 2 * WF_SPAN) - WF_SPAN);
      end
      issue_txn(idx, a, b, c, 1'b0, '0);
    end
    @(negedge clk);
    req_if.valid = 1'b0;

    // drain, then give a stray response time to show up
    while (pending_quats.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);

    $display("Covered %0d request transactions (%0d directed, %0d with index above 3),",
             req_sent, N_DIR, bad_idx_sent);
    $display("%0d responses checked, bursty requests, stalled receiver, one long hold-off.",
             rsp_checked);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #(LIMIT_NS);
    $display("Timeout: %0d responses still pending", pending_quats.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
